[sv/spmv_pkg.sv]
// Shared types, widths and codes for the sparse matrix-vector multiply unit.
package spmv_pkg;

    localparam int VECTOR_DEPTH = 1024;
    localparam int ADDR_W       = $clog2(VECTOR_DEPTH);

    localparam int FUNC_W = 3;
    localparam int IDX_W  = 10;
    localparam int VAL_W  = 32;
    localparam int FRAC_W = 16;
    localparam int PROD_W = 2 * VAL_W;
    localparam int TERM_W = PROD_W - FRAC_W;
    localparam int SUM_W  = TERM_W + 1;

    // input function codes
    localparam logic [FUNC_W-1:0] FUNC_LOAD_X  = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_NONZERO = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_EMPTY   = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_READ_Y  = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_RESTART = 3'd4;

    localparam logic signed [VAL_W-1:0] Q_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic signed [VAL_W-1:0] Q_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    // operation carried down the pipeline (x loads finish at the front)
    typedef enum logic [2:0] {
        OP_NONE,
        OP_NONZERO,
        OP_EMPTY,
        OP_READ_Y,
        OP_RESTART
    } op_t;

    typedef struct packed {
        logic                    sat;
        logic signed [VAL_W-1:0] val;
    } y_t;

    localparam int Y_W = $bits(y_t);

    typedef struct packed {
        logic                    valid;
        op_t                     op;
        logic [IDX_W-1:0]        index;
        logic signed [VAL_W-1:0] value;
        logic                    line_end;
        logic [IDX_W-1:0]        line_num;
        logic                    in_range;
        logic                    x_zero;
    } s1_t;

    typedef struct packed {
        logic                     valid;
        op_t                      op;
        logic [IDX_W-1:0]         index;
        logic                     line_end;
        logic [IDX_W-1:0]         line_num;
        logic                     in_range;
        logic signed [TERM_W-1:0] term;
        y_t                       y_rd;
    } s2_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        y_t                data;
    } ywr_t;

    typedef struct packed {
        logic                    valid;
        logic [IDX_W-1:0]        index;
        logic signed [VAL_W-1:0] value;
        logic                    sat;
    } res_t;

endpackage

[sv/spmv_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module spmv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

[sv/spmv_mul.sv]
// Multiply stage: Q16.16 product, rounded to nearest, into the accumulate stage.
module spmv_mul (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             adv,
    input  spmv_pkg::s1_t                    s1,
    input  logic signed [spmv_pkg::VAL_W-1:0] x_rdata,
    input  spmv_pkg::y_t                     y_rdata,
    output spmv_pkg::s2_t                    s2
);
    import spmv_pkg::*;

    localparam logic signed [PROD_W-1:0] ROUND_ADD = PROD_W'(1) << (FRAC_W - 1);

    logic signed [VAL_W-1:0]  x_val;
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] rounded;
    s2_t                      s2_reg;
    s2_t                      s2_next;

    always_comb begin
        x_val   = s1.x_zero ? '0 : x_rdata;
        prod    = PROD_W'(s1.value) * PROD_W'(x_val);
        // ties go up: add half an lsb, then floor
        rounded = prod + ROUND_ADD;

        s2_next.valid    = s1.valid;
        s2_next.op       = s1.op;
        s2_next.index    = s1.index;
        s2_next.line_end = s1.line_end;
        s2_next.line_num = s1.line_num;
        s2_next.in_range = s1.in_range;
        s2_next.term     = rounded[PROD_W-1:FRAC_W];
        s2_next.y_rd     = y_rdata;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_reg.valid <= 1'b0;
        end else if (adv) begin
            s2_reg <= s2_next;
        end
    end

    assign s2 = s2_reg;

endmodule

[sv/spmv_accum.sv]
// Accumulate stage: saturating add, row sum, y write-back with forwarding, results.
module spmv_accum (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           adv,
    input  logic           column_mode,
    input  spmv_pkg::s2_t  s2,
    output spmv_pkg::ywr_t ywr,
    output spmv_pkg::res_t res
);
    import spmv_pkg::*;

    logic signed [VAL_W-1:0] acc_reg;
    logic signed [VAL_W-1:0] acc_next;
    logic                    sat_reg;
    logic                    sat_next;
    ywr_t                    wb1_reg;
    ywr_t                    wb2_reg;

    logic [ADDR_W-1:0]       addr;
    y_t                      y_old;
    logic signed [VAL_W-1:0] opnd;
    logic signed [SUM_W-1:0] sum;
    logic                    clip;
    logic signed [VAL_W-1:0] clamped;

    // y entries written on the last two advances are not yet visible in the
    // read data this word carries
    always_comb begin
        addr = ADDR_W'(s2.index);
        if (wb1_reg.en && wb1_reg.addr == addr) begin
            y_old = wb1_reg.data;
        end else if (wb2_reg.en && wb2_reg.addr == addr) begin
            y_old = wb2_reg.data;
        end else begin
            y_old = s2.y_rd;
        end
    end

    always_comb begin
        opnd    = column_mode ? y_old.val : acc_reg;
        sum     = SUM_W'(s2.term) + SUM_W'(opnd);
        clip    = !((&sum[SUM_W-1:VAL_W-1]) || !(|sum[SUM_W-1:VAL_W-1]));
        clamped = clip ? (sum[SUM_W-1] ? Q_MIN : Q_MAX) : sum[VAL_W-1:0];
    end

    always_comb begin
        acc_next  = acc_reg;
        sat_next  = sat_reg;
        res       = '0;
        ywr.en    = 1'b0;
        ywr.addr  = addr;
        ywr.data  = '0;
        if (s2.valid) begin
            unique case (s2.op)
                OP_NONZERO: begin
                    if (!column_mode) begin
                        if (s2.line_end) begin
                            res.valid = 1'b1;
                            res.index = s2.line_num;
                            res.value = clamped;
                            res.sat   = sat_reg | clip;
                            acc_next  = '0;
                            sat_next  = 1'b0;
                        end else begin
                            acc_next = clamped;
                            sat_next = sat_reg | clip;
                        end
                    end else if (s2.in_range) begin
                        ywr.en       = 1'b1;
                        ywr.data.val = clamped;
                        ywr.data.sat = y_old.sat | clip;
                    end
                end
                OP_EMPTY: begin
                    if (!column_mode) begin
                        res.valid = 1'b1;
                        res.index = s2.line_num;
                        res.value = acc_reg;
                        res.sat   = sat_reg;
                        acc_next  = '0;
                        sat_next  = 1'b0;
                    end
                end
                OP_READ_Y: begin
                    res.valid = 1'b1;
                    res.index = s2.index;
                    if (s2.in_range) begin
                        res.value = y_old.val;
                        res.sat   = y_old.sat;
                        ywr.en    = 1'b1;
                    end
                end
                OP_RESTART: begin
                    acc_next = '0;
                    sat_next = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg    <= '0;
            sat_reg    <= 1'b0;
            wb1_reg.en <= 1'b0;
            wb2_reg.en <= 1'b0;
        end else if (adv) begin
            acc_reg <= acc_next;
            sat_reg <= sat_next;
            wb1_reg <= ywr;
            wb2_reg <= wb1_reg;
        end
    end

endmodule

[sv/sparse_matrix_vector_multiply_unit.sv]
// Top level: input decode, line counter, x and y stores, pipeline and result register.
//
//  Channel   Ports                                   Direction  Handshake
//  input     s_func s_index s_value s_line_end       in         s_valid / s_ready
//  result    m_result_index m_result_value m_saturated out      m_valid / m_ready
//  config    cfg_wr_data (column_mode)               in         cfg_wr_en
//
//  One word per cycle sustained while the pipe does not hold; a result reaches the output
//  register after its word is accepted (x/y read at the accept edge, multiply, accumulate).
//  After reset the y store is cleared one entry per cycle over all VECTOR_DEPTH entries;
//  s_ready stays low during the sweep, config writes still land.
//  When the result register is full and m_ready is low the whole pipe holds.
module sparse_matrix_vector_multiply_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic                              cfg_wr_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [spmv_pkg::FUNC_W-1:0]        s_func,
    input  logic [spmv_pkg::IDX_W-1:0]         s_index,
    input  logic signed [spmv_pkg::VAL_W-1:0]  s_value,
    input  logic                              s_line_end,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [spmv_pkg::IDX_W-1:0]         m_result_index,
    output logic signed [spmv_pkg::VAL_W-1:0]  m_result_value,
    output logic                              m_saturated
);
    import spmv_pkg::*;

    logic                    column_mode_reg;
    logic                    clr_active_reg;
    logic [ADDR_W-1:0]       clr_addr_reg;
    logic [IDX_W-1:0]        line_count_reg;
    logic [IDX_W-1:0]        line_count_next;

    logic                    adv;
    logic                    accept;
    logic                    idx_in_range;
    logic                    lc_in_range;
    op_t                     op;
    s1_t                     s1_reg;
    s1_t                     s1_next;
    s2_t                     s2;
    ywr_t                    ywr;
    res_t                    res;

    logic                    x_we;
    logic [ADDR_W-1:0]       x_raddr;
    logic signed [VAL_W-1:0] x_rdata;
    logic                    y_we;
    logic [ADDR_W-1:0]       y_waddr;
    y_t                      y_wdata;
    y_t                      y_rdata;

    logic                    m_valid_reg;
    logic [IDX_W-1:0]        m_index_reg;
    logic signed [VAL_W-1:0] m_value_reg;
    logic                    m_sat_reg;

    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = !clr_active_reg && adv;
    assign accept  = s_valid && s_ready;

    assign idx_in_range = 32'(s_index) < 32'(VECTOR_DEPTH);
    assign lc_in_range  = 32'(line_count_reg) < 32'(VECTOR_DEPTH);

    always_comb begin
        unique case (s_func)
            FUNC_NONZERO: op = OP_NONZERO;
            FUNC_EMPTY:   op = OP_EMPTY;
            FUNC_READ_Y:  op = OP_READ_Y;
            FUNC_RESTART: op = OP_RESTART;
            default:      op = OP_NONE;
        endcase
    end

    always_comb begin
        line_count_next = line_count_reg;
        if (op == OP_RESTART) begin
            line_count_next = '0;
        end else if ((op == OP_NONZERO && s_line_end) || op == OP_EMPTY) begin
            line_count_next = line_count_reg + IDX_W'(1);
        end
    end

    // row mode reads x at the inner index, column mode at the current column
    always_comb begin
        x_raddr = column_mode_reg ? ADDR_W'(line_count_reg) : ADDR_W'(s_index);
        x_we    = accept && s_func == FUNC_LOAD_X && idx_in_range;

        s1_next.valid    = accept;
        s1_next.op       = op;
        s1_next.index    = s_index;
        s1_next.value    = s_value;
        s1_next.line_end = s_line_end;
        s1_next.line_num = line_count_reg;
        s1_next.in_range = idx_in_range;
        s1_next.x_zero   = column_mode_reg ? !lc_in_range : !idx_in_range;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_mode_reg <= 1'b0;
            clr_active_reg  <= 1'b1;
            clr_addr_reg    <= '0;
            line_count_reg  <= '0;
            s1_reg.valid    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                column_mode_reg <= cfg_wr_data;
            end
            if (clr_active_reg) begin
                clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
                if (clr_addr_reg == ADDR_W'(VECTOR_DEPTH - 1)) begin
                    clr_active_reg <= 1'b0;
                end
            end
            if (accept) begin
                line_count_reg <= line_count_next;
            end
            if (adv) begin
                s1_reg <= s1_next;
            end
        end
    end

    spmv_ram #(
        .WIDTH (VAL_W),
        .DEPTH (VECTOR_DEPTH)
    ) u_x_ram (
        .aclk  (aclk),
        .we    (x_we),
        .waddr (ADDR_W'(s_index)),
        .wdata (s_value),
        .re    (accept),
        .raddr (x_raddr),
        .rdata (x_rdata)
    );

    always_comb begin
        y_we    = clr_active_reg || (adv && ywr.en);
        y_waddr = clr_active_reg ? clr_addr_reg : ywr.addr;
        y_wdata = clr_active_reg ? y_t'('0) : ywr.data;
    end

    spmv_ram #(
        .WIDTH (Y_W),
        .DEPTH (VECTOR_DEPTH)
    ) u_y_ram (
        .aclk  (aclk),
        .we    (y_we),
        .waddr (y_waddr),
        .wdata (y_wdata),
        .re    (accept),
        .raddr (ADDR_W'(s_index)),
        .rdata (y_rdata)
    );

    spmv_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .adv     (adv),
        .s1      (s1_reg),
        .x_rdata (x_rdata),
        .y_rdata (y_rdata),
        .s2      (s2)
    );

    spmv_accum u_accum (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .adv         (adv),
        .column_mode (column_mode_reg),
        .s2          (s2),
        .ywr         (ywr),
        .res         (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= res.valid;
            if (res.valid) begin
                m_index_reg <= res.index;
                m_value_reg <= res.value;
                m_sat_reg   <= res.sat;
            end
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_result_index = m_index_reg;
    assign m_result_value = m_value_reg;
    assign m_saturated    = m_sat_reg;

endmodule

[test/tb_sparse_matrix_vector_multiply_unit.sv]
// Self-checking testbench for the sparse matrix-vector multiply unit: directed table, then random lines.
module tb_sparse_matrix_vector_multiply_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import spmv_pkg::*;

    localparam int PIPE_LATENCY = 3;
    localparam int DRAIN_CYCLES = 2 * PIPE_LATENCY + 2;
    localparam int TAIL_CYCLES  = 4 * PIPE_LATENCY + 4;
    // covers the y clearing sweep after reset plus the longest random stall
    localparam int STALL_LIMIT  = 4 * VECTOR_DEPTH + 1000;
    localparam int LINE_WORDS   = 36;

    localparam logic [FUNC_W-1:0] FUNC_SPARE_LO = 3'd5;
    localparam logic [FUNC_W-1:0] FUNC_SPARE_HI = 3'd7;
    localparam bit MODE_ROW = 1'b0;
    localparam bit MODE_COL = 1'b1;

    typedef struct packed {
        logic [IDX_W-1:0]        idx;
        logic signed [VAL_W-1:0] val;
        logic                    sat;
    } y_word_t;

    localparam y_word_t NO_WORD = '0;

    typedef struct packed {
        logic             wr_mode;
        logic             mode;
        logic [FUNC_W-1:0] func;
        logic [IDX_W-1:0] idx;
        logic [VAL_W-1:0] val;
        logic             le;
        logic             typed;
        y_word_t          want;
    } step_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic cfg_wr_data = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [FUNC_W-1:0] s_func = '0;
    logic [IDX_W-1:0] s_index = '0;
    logic signed [VAL_W-1:0] s_value = '0;
    logic s_line_end = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [IDX_W-1:0] m_result_index;
    logic signed [VAL_W-1:0] m_result_value;
    logic m_saturated;

    // what the word on the input port should produce, when typed in by hand
    logic    drv_typed = 1'b0;
    y_word_t drv_want = '0;

    int unsigned s_gap_pct = 6;
    int unsigned m_stall_pct = 77;
    int bad_count = 0;
    int idle_cycles = 0;

    // predictor state
    logic signed [VAL_W-1:0] x_mem [VECTOR_DEPTH];
    bit                      x_known [VECTOR_DEPTH];
    logic [IDX_W-1:0]        x_known_list [$];
    logic signed [VAL_W-1:0] y_val [VECTOR_DEPTH] = '{default: '0};
    bit                      y_clip [VECTOR_DEPTH];
    longint                  row_acc = 0;
    bit                      row_clip = 1'b0;
    logic [IDX_W-1:0]        line_num = '0;
    bit                      col_mode = MODE_ROW;

    y_word_t pending_y [$];

    step_t directed_steps [0:26] = '{
        // y store reads as zero after the reset sweep
        '{'0, '0, FUNC_READ_Y,   10'd0,    32'h0000_0000, '0, '1, '{10'd0,    32'h0, '0}},
        '{'0, '0, FUNC_READ_Y,   10'd1023, 32'h0000_0000, '1, '1, '{10'd1023, 32'h0, '0}},
        '{'0, '0, FUNC_LOAD_X,   10'd0,    32'h0001_0000, '0, '0, NO_WORD},
        '{'0, '0, FUNC_LOAD_X,   10'd1023, Q_MAX,         '0, '0, NO_WORD},
        '{'0, '0, FUNC_LOAD_X,   10'd1,    Q_MIN,         '0, '0, NO_WORD},
        '{'0, '0, FUNC_LOAD_X,   10'd2,    32'hFFFF_8000, '0, '0, NO_WORD},
        '{'0, '0, FUNC_NONZERO,  10'd0,    32'h0002_0000, '1, '1, '{10'd0, 32'h0002_0000, '0}},
        '{'0, '0, FUNC_EMPTY,    10'd0,    32'h0000_0000, '0, '1, '{10'd1, 32'h0, '0}},
        // clip high, then clip low: flag stays set
        '{'0, '0, FUNC_NONZERO,  10'd1023, Q_MAX,         '0, '0, NO_WORD},
        '{'0, '0, FUNC_NONZERO,  10'd1,    Q_MAX,         '1, '1, '{10'd2, Q_MIN, '1}},
        // rounding ties go toward plus infinity
        '{'0, '0, FUNC_NONZERO,  10'd2,    32'h0000_0001, '0, '0, NO_WORD},
        '{'0, '0, FUNC_NONZERO,  10'd2,    32'hFFFF_FFFF, '0, '0, NO_WORD},
        // open row closed by an empty line
        '{'0, '0, FUNC_EMPTY,    10'd0,    32'h0000_0000, '0, '0, NO_WORD},
        '{'0, '0, FUNC_SPARE_LO, 10'd5,    32'h0000_0000, '0, '0, NO_WORD},
        '{'0, '0, FUNC_SPARE_HI, 10'd1023, 32'hFFFF_FFFF, '1, '0, NO_WORD},
        '{'0, '0, FUNC_NONZERO,  10'd0,    32'h0003_0000, '0, '0, NO_WORD},
        '{'0, '0, FUNC_RESTART,  10'd0,    32'h0000_0000, '0, '0, NO_WORD},
        '{'0, '0, FUNC_EMPTY,    10'd0,    32'h0000_0000, '0, '1, '{10'd0, 32'h0, '0}},
        '{'1, MODE_COL, FUNC_LOAD_X, 10'd0, 32'h0000_0000, '0, '0, NO_WORD},
        '{'0, '0, FUNC_NONZERO,  10'd5,    32'h0001_0000, '0, '0, NO_WORD},
        '{'0, '0, FUNC_NONZERO,  10'd5,    32'hFFFF_0000, '1, '0, NO_WORD},
        '{'0, '0, FUNC_NONZERO,  10'd7,    Q_MIN,         '0, '0, NO_WORD},
        '{'0, '0, FUNC_NONZERO,  10'd7,    Q_MIN,         '1, '0, NO_WORD},
        '{'0, '0, FUNC_EMPTY,    10'd0,    32'h0000_0000, '0, '0, NO_WORD},
        '{'0, '0, FUNC_READ_Y,   10'd5,    32'h0000_0000, '0, '0, NO_WORD},
        '{'0, '0, FUNC_READ_Y,   10'd7,    32'h0000_0000, '0, '0, NO_WORD},
        // read also clears
        '{'0, '0, FUNC_READ_Y,   10'd7,    32'h0000_0000, '0, '1, '{10'd7, 32'h0, '0}}
    };

    sparse_matrix_vector_multiply_unit u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_func         (s_func),
        .s_index        (s_index),
        .s_value        (s_value),
        .s_line_end     (s_line_end),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_index (m_result_index),
        .m_result_value (m_result_value),
        .m_saturated    (m_saturated)
    );

    always #2 aclk = ~aclk;

    // Q16.16 product rounded to nearest, ties up
    function automatic longint q_mul(input logic signed [VAL_W-1:0] a,
                                     input logic signed [VAL_W-1:0] b);
        longint p;
        p = longint'(a) * longint'(b) + 64'sd32768;
        return p >>> FRAC_W;
    endfunction

    function automatic longint clip_add(input longint acc, input longint term, inout bit clip);
        longint s;
        s = acc + term;
        if (s > longint'(Q_MAX)) begin
            clip = 1'b1;
            return longint'(Q_MAX);
        end
        if (s < longint'(Q_MIN)) begin
            clip = 1'b1;
            return longint'(Q_MIN);
        end
        return s;
    endfunction

    function automatic y_word_t close_row();
        y_word_t w;
        w = '{line_num, VAL_W'(row_acc), row_clip};
        row_acc = 0;
        row_clip = 1'b0;
        line_num = line_num + 1'b1;
        return w;
    endfunction

    task automatic compute_y_word(input logic [FUNC_W-1:0] func, input logic [IDX_W-1:0] idx,
                                  input logic signed [VAL_W-1:0] val, input logic le,
                                  output bit got, output y_word_t w);
        longint sum;
        bit clip;
        got = 1'b0;
        w = NO_WORD;
        case (func)
            FUNC_LOAD_X: begin
                x_mem[idx] = val;
                if (!x_known[idx]) begin
                    x_known[idx] = 1'b1;
                    x_known_list.push_back(idx);
                end
            end
            FUNC_NONZERO: begin
                if (col_mode == MODE_ROW) begin
                    row_acc = clip_add(row_acc, q_mul(val, x_mem[idx]), row_clip);
                    if (le) begin
                        w = close_row();
                        got = 1'b1;
                    end
                end else begin
                    clip = y_clip[idx];
                    sum = clip_add(longint'(y_val[idx]), q_mul(val, x_mem[line_num]), clip);
                    y_val[idx] = VAL_W'(sum);
                    y_clip[idx] = clip;
                    if (le)
                        line_num = line_num + 1'b1;
                end
            end
            FUNC_EMPTY: begin
                if (col_mode == MODE_ROW) begin
                    w = close_row();
                    got = 1'b1;
                end else begin
                    line_num = line_num + 1'b1;
                end
            end
            FUNC_READ_Y: begin
                w = '{idx, y_val[idx], y_clip[idx]};
                got = 1'b1;
                y_val[idx] = '0;
                y_clip[idx] = 1'b0;
            end
            FUNC_RESTART: begin
                row_acc = 0;
                row_clip = 1'b0;
                line_num = '0;
            end
            default: ;
        endcase
    endtask

    task automatic note_mismatch(input string what, input logic [VAL_W-1:0] got,
                                 input logic [VAL_W-1:0] want);
        $display("%0t ns: mismatch on %s: got %h, expected %h", $time, what, got, want);
        bad_count++;
    endtask

    function automatic logic [VAL_W-1:0] pick_q();
        case ($urandom_range(3))
            0: return $urandom;
            1: begin
                case ($urandom_range(4))
                    0: return Q_MAX;
                    1: return Q_MIN;
                    2: return '0;
                    3: return 32'h0001_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            default: return $urandom_range(32'h0007_FFFF) - 32'h0004_0000;
        endcase
    endfunction

    // mostly a small set of y entries so that products pile up
    function automatic logic [IDX_W-1:0] pick_y_idx();
        if ($urandom_range(3) == 0)
            return IDX_W'($urandom_range(VECTOR_DEPTH - 1));
        return IDX_W'($urandom_range(15));
    endfunction

    // called at a falling edge, returns at the falling edge after the word is taken
    task automatic send_word(input logic [FUNC_W-1:0] func, input logic [IDX_W-1:0] idx,
                             input logic [VAL_W-1:0] val, input logic le,
                             input logic typed, input y_word_t want);
        while ($urandom_range(99) < s_gap_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid    <= 1'b1;
        s_func     <= func;
        s_index    <= idx;
        s_value    <= val;
        s_line_end <= le;
        drv_typed  <= typed;
        drv_want   <= want;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    // mode may only change with the pipe empty
    task automatic set_mode(input bit mode);
        s_valid <= 1'b0;
        while (pending_y.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= mode;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic run_lines(input int unsigned n);
        int unsigned done;
        int unsigned r;
        int unsigned len;
        bit closes;
        logic [IDX_W-1:0] at;
        done = 0;
        while (done < n) begin
            r = $urandom_range(99);
            if (r < 10) begin
                send_word(FUNC_LOAD_X, IDX_W'($urandom_range(VECTOR_DEPTH - 1)), pick_q(),
                          1'($urandom_range(1)), 1'b0, NO_WORD);
                done++;
            end else if (r < 70) begin
                // a line of nonzeros; some are left open and continue later
                closes = (r < 62);
                len = closes ? $urandom_range(4, 1) : $urandom_range(3, 1);
                if (col_mode == MODE_COL && !x_known[line_num]) begin
                    send_word(FUNC_LOAD_X, line_num, pick_q(), 1'b0, 1'b0, NO_WORD);
                    done++;
                end
                for (int k = 0; k < len; k++) begin
                    if (col_mode == MODE_COL)
                        at = pick_y_idx();
                    else
                        at = x_known_list[$urandom_range(x_known_list.size() - 1)];
                    send_word(FUNC_NONZERO, at, pick_q(), closes && (k == len - 1),
                              1'b0, NO_WORD);
                    done++;
                end
            end else if (r < 84) begin
                send_word(FUNC_READ_Y, pick_y_idx(), pick_q(), 1'($urandom_range(1)),
                          1'b0, NO_WORD);
                done++;
            end else if (r < 88) begin
                send_word(FUNC_RESTART, IDX_W'($urandom), $urandom, 1'($urandom_range(1)),
                          1'b0, NO_WORD);
                done++;
            end else if (r < 93) begin
                send_word(FUNC_W'($urandom_range(FUNC_SPARE_HI, FUNC_SPARE_LO)),
                          IDX_W'($urandom), $urandom, 1'($urandom_range(1)), 1'b0, NO_WORD);
            end else begin
                send_word(FUNC_EMPTY, IDX_W'($urandom), $urandom, 1'($urandom_range(1)),
                          1'b0, NO_WORD);
                done++;
            end
        end
    endtask

    always @(negedge aclk)
        m_ready <= ($urandom_range(99) >= m_stall_pct);

    always @(posedge aclk) begin
        bit got;
        y_word_t w;
        if (aresetn) begin
            if (cfg_wr_en)
                col_mode = cfg_wr_data;
            if (s_valid && s_ready) begin
                compute_y_word(s_func, s_index, s_value, s_line_end, got, w);
                if (drv_typed)
                    pending_y.push_back(drv_want);
                else if (got)
                    pending_y.push_back(w);
            end
            if (m_valid && m_ready) begin
                if (pending_y.size() == 0) begin
                    note_mismatch("unexpected result, index", VAL_W'(m_result_index), '0);
                end else begin
                    w = pending_y.pop_front();
                    if (m_result_index !== w.idx)
                        note_mismatch("result_index", VAL_W'(m_result_index), VAL_W'(w.idx));
                    if (m_result_value !== w.val)
                        note_mismatch("result_value", m_result_value, w.val);
                    if (m_saturated !== w.sat)
                        note_mismatch("saturated", VAL_W'(m_saturated), VAL_W'(w.sat));
                end
            end
        end
    end

    // watchdog: nothing moving on either channel for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        set_mode(MODE_ROW);

        foreach (directed_steps[i]) begin
            if (directed_steps[i].wr_mode)
                set_mode(directed_steps[i].mode);
            else
                send_word(directed_steps[i].func, directed_steps[i].idx, directed_steps[i].val,
                          directed_steps[i].le, directed_steps[i].typed,
                          directed_steps[i].want);
        end

        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin s_gap_pct = 6;  m_stall_pct = 77; end
                1: begin s_gap_pct = 77; m_stall_pct = 6;  end
                default: begin s_gap_pct = 0; m_stall_pct = 0; end
            endcase
            for (int k = 0; k < 2; k++) begin
                set_mode(((ph + k) % 2) ? MODE_COL : MODE_ROW);
                if (ph == 2 && k == 0) begin
                    // run the line counter through its wrap
                    do
                        send_word(FUNC_EMPTY, IDX_W'($urandom), $urandom,
                                  1'($urandom_range(1)), 1'b0, NO_WORD);
                    while (line_num != '0);
                end
                run_lines(LINE_WORDS);
            end
        end

        s_valid <= 1'b0;
        while (pending_y.size() != 0)
            @(negedge aclk);
        repeat (TAIL_CYCLES) @(negedge aclk);
        if (bad_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
